@@ sv/online_lp_dual_update_engine_defines.svh @@
// Assertion macros shared by the online LP dual update engine
`ifndef ONLINE_LP_DUAL_UPDATE_ENGINE_DEFINES_SVH
`define ONLINE_LP_DUAL_UPDATE_ENGINE_DEFINES_SVH

// Property that holds at every clock edge outside reset
`define OLP_CHECK(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Condition in one cycle implies a consequence in the next
`define OLP_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

@@ sv/olp_pkg.sv @@
// Types and constants of the online LP dual update engine
package olp_pkg;

    localparam int DEF_ROWS               = 1024;
    localparam int DEF_MAX_COLUMN_ENTRIES = 64;
    localparam int DEF_FRACTION_BITS      = 16;
    localparam int STEP_SHIFT             = 16;
    localparam int CFG_DATA_W             = 16;

    typedef enum logic [1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_ENTRY = 2'd1,
        FUNC_CLOSE = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic {
        CFG_STEP_SIZE     = 1'b0,
        CFG_DUAL_INIT_ONE = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [1:0]         func;
        logic [9:0]         row_index;
        logic signed [31:0] entry_value;
        logic signed [31:0] row_share;
        logic               is_equality;
        logic [15:0]        column_id;
        logic signed [31:0] objective;
        logic               last_in_column;
    } in_item_t;

    typedef struct packed {
        logic [15:0] out_column_id;
        logic        take_column;
        logic        buffer_overflow;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] price;
        logic signed [31:0] share;
        logic               equality;
        logic [31:0]        stamp;
    } row_word_t;

    // Saturate a 43-bit signed value to 32 bits
    function automatic logic signed [31:0] sat43(input logic signed [42:0] v);
        logic signed [42:0] hi;
        logic signed [42:0] lo;
        begin
            hi = 43'sh7FFF_FFFF;
            lo = -43'sh8000_0000;
            if (v > hi)
                sat43 = 32'sh7FFF_FFFF;
            else if (v < lo)
                sat43 = 32'sh8000_0000;
            else
                sat43 = v[31:0];
        end
    endfunction

endpackage

@@ sv/olp_ram.sv @@
// Single-port-write, registered-read synchronous RAM
module olp_ram
    import olp_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = 6
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

@@ sv/online_lp_dual_update_engine.sv @@
// Online LP dual update engine: row price memory, entry buffer and sequencer
//
// Input channel (in_valid/in_ready/in_data) carries one transaction per item:
// a row load, a column entry or an empty column close. Output channel
// (out_valid/out_ready/out_data) carries one decision per closed column.
// Configuration: cfg_write with cfg_index/cfg_data, taken on the clock edge.
// Items are handled one at a time. A row load or an ignored code is done in
// the idle state as it is taken; a column entry passes through row memory
// read, two registered multiply stages for the lazy decay, price write-back,
// priced product and sum update. A column close makes the decision, then,
// when the column is taken, replays each buffered entry (buffer read, row
// address, row read, multiply, write back), then loads the output register.
// The row memory's single read port and dependent multiplies force this order.
// The output register frees the input side: new items are taken while a
// decision waits; only a second decision waits until the first is taken.
// Reset clears the counter, the sum, the buffer fill and the handshakes; rows
// must be loaded before use. There is no clearing pass.
module online_lp_dual_update_engine
    import olp_pkg::*;
#(
    parameter int ROWS               = DEF_ROWS,
    parameter int MAX_COLUMN_ENTRIES = DEF_MAX_COLUMN_ENTRIES,
    parameter int FRACTION_BITS      = DEF_FRACTION_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_write,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    `include "online_lp_dual_update_engine_defines.svh"

    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int BUF_AW = (MAX_COLUMN_ENTRIES > 1) ? $clog2(MAX_COLUMN_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(MAX_COLUMN_ENTRIES + 1);
    localparam int BUF_W  = ROW_AW + 32;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_COLUMN_ENTRIES);
    localparam logic [63:0] DECAY_CAP = 64'd1 << 40;

    typedef enum logic [3:0] {
        S_IDLE, S_DRD, S_D1, S_D2, S_D3, S_D4, S_D5,
        S_FIN, S_RA, S_RB, S_RR, S_RM, S_RW, S_EMIT
    } state_t;

    state_t              state_reg;
    logic [15:0]         step_reg;
    logic                init_one_reg;
    logic [31:0]         counter_reg;
    logic signed [63:0]  sum_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                ovf_reg;
    logic [CNT_W-1:0]    k_reg;
    logic                take_reg;
    logic                out_valid_reg;
    out_item_t           out_data_reg;

    in_item_t            item_reg;
    logic [ROW_AW-1:0]   r_reg;
    row_word_t           row_reg;
    logic signed [31:0]  val_reg;
    logic signed [48:0]  prod_reg;
    logic [31:0]         delta_reg;
    logic [63:0]         pl_reg;
    logic [47:0]         ph_reg;
    logic signed [31:0]  newp_reg;
    logic signed [63:0]  p_reg;
    logic signed [49:0]  rprod_reg;

    row_word_t           row_rdata;
    logic                row_we;
    logic [ROW_AW-1:0]   row_waddr;
    row_word_t           row_wdata;
    logic [BUF_W-1:0]    buf_rdata;
    logic                buf_we;

    logic                accept;
    logic [ROW_AW-1:0]   r_sel;
    logic                emit_go;

    logic [47:0]         mag;
    logic [79:0]         full;
    logic [63:0]         dec_raw;
    logic [42:0]         dec;
    logic signed [42:0]  y_dec;
    logic signed [31:0]  y_sat;
    logic signed [31:0]  y_new;
    logic signed [64:0]  sum_ext;
    logic signed [63:0]  sum_sat;
    logic signed [63:0]  obj_scaled;
    logic signed [49:0]  rprod_adj;
    logic signed [33:0]  inc;
    logic signed [42:0]  y_rep;
    logic signed [31:0]  y_rep_sat;
    logic signed [31:0]  y_rep_new;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign r_sel     = ROW_AW'(32'(in_data.row_index) % ROWS);
    assign emit_go   = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Lazy decay: |step*d| * elapsed, split in two partial products
    always_comb
    begin
        mag     = prod_reg[48] ? 48'(-prod_reg) : 48'(prod_reg);
        full    = {ph_reg, 32'd0} + {16'd0, pl_reg};
        dec_raw = full[79:16];
        dec     = (dec_raw > DECAY_CAP) ? 43'(DECAY_CAP) : dec_raw[42:0];
        y_dec   = prod_reg[48] ? 43'(row_reg.price) + $signed(dec)
                               : 43'(row_reg.price) - $signed(dec);
        y_sat   = sat43(y_dec);
        y_new   = (!row_reg.equality && y_sat < 0) ? 32'sd0 : y_sat;
    end

    // Saturating accumulate of the priced product
    always_comb
    begin
        sum_ext = 65'(sum_reg) + 65'(p_reg);
        if (sum_ext > 65'sh0_7FFF_FFFF_FFFF_FFFF)
            sum_sat = 64'sh7FFF_FFFF_FFFF_FFFF;
        else if (sum_ext < -65'sh0_8000_0000_0000_0000)
            sum_sat = 64'sh8000_0000_0000_0000;
        else
            sum_sat = sum_ext[63:0];
        obj_scaled = 64'($signed(item_reg.objective)) <<< FRACTION_BITS;
    end

    // Replay step: truncate step*(value - d) / 2^16 toward zero
    always_comb
    begin
        rprod_adj = rprod_reg[49] ? rprod_reg + 50'sd65535 : rprod_reg;
        inc       = 34'(rprod_adj >>> STEP_SHIFT);
        y_rep     = 43'(row_reg.price) + 43'(inc);
        y_rep_sat = sat43(y_rep);
        y_rep_new = (!row_reg.equality && y_rep_sat < 0) ? 32'sd0 : y_rep_sat;
    end

    always_comb
    begin
        row_we    = 1'b0;
        row_waddr = r_reg;
        row_wdata = row_reg;
        case (state_reg)
            S_IDLE:
            begin
                row_we          = accept && (in_data.func == FUNC_LOAD);
                row_waddr       = r_sel;
                row_wdata.price = init_one_reg ? 32'(64'd1 << FRACTION_BITS) : 32'sd0;
                row_wdata.share = in_data.row_share;
                row_wdata.equality = in_data.is_equality;
                row_wdata.stamp = counter_reg;
            end
            S_D3:
            begin
                row_we          = 1'b1;
                row_wdata.price = y_new;
                row_wdata.stamp = counter_reg;
            end
            S_RW:
            begin
                row_we          = 1'b1;
                row_wdata.price = y_rep_new;
                row_wdata.stamp = counter_reg;
            end
            default:
            begin
                row_we = 1'b0;
            end
        endcase
    end

    assign buf_we = (state_reg == S_D5) && (count_reg < MAX_CNT);

    olp_ram #(
        .WIDTH ($bits(row_word_t)),
        .DEPTH (ROWS),
        .AW    (ROW_AW)
    ) u_row_mem (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .raddr (r_reg),
        .rdata (row_rdata)
    );

    olp_ram #(
        .WIDTH (BUF_W),
        .DEPTH (MAX_COLUMN_ENTRIES),
        .AW    (BUF_AW)
    ) u_entry_buf (
        .clk   (clk),
        .we    (buf_we),
        .waddr (count_reg[BUF_AW-1:0]),
        .wdata ({r_reg, item_reg.entry_value}),
        .raddr (k_reg[BUF_AW-1:0]),
        .rdata (buf_rdata)
    );

    // Sequencer and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            init_one_reg  <= 1'b0;
            counter_reg   <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            k_reg         <= '0;
            take_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_STEP_SIZE:     step_reg     <= cfg_data;
                    CFG_DUAL_INIT_ONE: init_one_reg <= cfg_data[0];
                    default:           step_reg     <= step_reg;
                endcase
            end
            // Drop the decision once taken, unless a new one is loaded now
            if (out_valid_reg && out_ready && state_reg != S_EMIT)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (in_data.func)
                            FUNC_ENTRY: state_reg <= S_DRD;
                            FUNC_CLOSE: state_reg <= S_FIN;
                            default:    state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_DRD: state_reg <= S_D1;
                S_D1:  state_reg <= S_D2;
                S_D2:  state_reg <= S_D3;
                S_D3:  state_reg <= S_D4;
                S_D4:  state_reg <= S_D5;
                S_D5:
                begin
                    sum_reg <= sum_sat;
                    if (count_reg < MAX_CNT)
                        count_reg <= count_reg + 1'b1;
                    else
                        ovf_reg <= 1'b1;
                    state_reg <= item_reg.last_in_column ? S_FIN : S_IDLE;
                end
                S_FIN:
                begin
                    take_reg    <= (obj_scaled >= sum_reg);
                    counter_reg <= counter_reg + 1'b1;
                    k_reg       <= '0;
                    state_reg   <= ((obj_scaled >= sum_reg) && count_reg != '0) ? S_RA
                                                                               : S_EMIT;
                end
                S_RA: state_reg <= S_RB;
                S_RB: state_reg <= S_RR;
                S_RR: state_reg <= S_RM;
                S_RM: state_reg <= S_RW;
                S_RW:
                begin
                    k_reg     <= k_reg + 1'b1;
                    state_reg <= (k_reg + 1'b1 == count_reg) ? S_EMIT : S_RA;
                end
                S_EMIT:
                begin
                    if (emit_go)
                    begin
                        out_valid_reg                <= 1'b1;
                        out_data_reg.out_column_id   <= item_reg.column_id;
                        out_data_reg.take_column     <= take_reg;
                        out_data_reg.buffer_overflow <= ovf_reg;
                        sum_reg   <= '0;
                        count_reg <= '0;
                        ovf_reg   <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    item_reg <= in_data;
                    r_reg    <= r_sel;
                end
            end
            S_D1:
            begin
                row_reg   <= row_rdata;
                prod_reg  <= $signed({1'b0, step_reg}) * row_rdata.share;
                delta_reg <= counter_reg - row_rdata.stamp;
            end
            S_D2:
            begin
                pl_reg <= 64'(mag[31:0]) * 64'(delta_reg);
                ph_reg <= 48'(mag[47:32]) * 48'(delta_reg);
            end
            S_D3: newp_reg <= y_new;
            S_D4: p_reg    <= 64'(item_reg.entry_value) * 64'(newp_reg);
            S_RB:
            begin
                r_reg   <= buf_rdata[BUF_W-1:32];
                val_reg <= $signed(buf_rdata[31:0]);
            end
            S_RM:
            begin
                row_reg   <= row_rdata;
                rprod_reg <= $signed({1'b0, step_reg})
                           * (33'(val_reg) - 33'(row_rdata.share));
            end
            default:
            begin
                newp_reg <= newp_reg;
            end
        endcase
    end

    `OLP_CHECK(a_count_bound, count_reg <= MAX_CNT, "entry count beyond buffer depth")
    `OLP_CHECK(a_ovf_full, !ovf_reg || count_reg == MAX_CNT, "overflow with buffer not full")
    `OLP_CHECK(a_replay_index, !(state_reg == S_RW) || k_reg < count_reg,
        "replay index past fill")
    `OLP_NEXT(a_emit_clears, state_reg == S_EMIT && emit_go,
        count_reg == '0 && sum_reg == '0 && out_valid_reg, "column state not cleared on emit")

endmodule

@@ dv/online_lp_dual_update_checker.sv @@
// Decision checker for the online LP dual update engine: predicts and compares
`timescale 1ns / 1ps
module online_lp_dual_update_checker
    import olp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  in_item_t    in_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  out_item_t   out_data,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending_decisions,
    output int          decisions_seen,
    output int          takes_seen
);

    localparam int NROWS = 1024;
    localparam int NBUF  = 64;

    logic [15:0]        step_q;
    logic               init_one_q;
    logic signed [31:0] price_mem [NROWS];
    logic signed [31:0] share_mem [NROWS];
    logic               eq_mem [NROWS];
    logic [31:0]        stamp_mem [NROWS];
    logic [31:0]        col_counter;
    logic signed [63:0] dot_sum;
    logic [9:0]         buf_row [NBUF];
    logic signed [31:0] buf_val [NBUF];
    int                 buf_fill;
    logic               buf_over;
    out_item_t          decision_q[$];

    function automatic logic signed [31:0] sat_price(input logic signed [127:0] v);
        if (v > 128'sh7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        if (v < -128'sh8000_0000)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] clamp_price(input int r,
                                                       input logic signed [31:0] y);
        if (!eq_mem[r] && y < 0)
            return 0;
        return y;
    endfunction

    task automatic decay_price(input int r);
        logic signed [127:0] prod;
        logic [127:0]        mag;
        logic [127:0]        dec;
        logic [31:0]         elapsed;
        prod    = $signed({1'b0, step_q}) * share_mem[r];
        mag     = prod < 0 ? -prod : prod;
        elapsed = col_counter - stamp_mem[r];
        dec     = (mag * elapsed) >> 16;
        if (dec > (128'd1 << 40))
            dec = 128'd1 << 40;
        if (prod < 0)
            price_mem[r] = clamp_price(r, sat_price(price_mem[r] + $signed(dec)));
        else
            price_mem[r] = clamp_price(r, sat_price(price_mem[r] - $signed(dec)));
        stamp_mem[r] = col_counter;
    endtask

    task automatic close_column(input in_item_t it);
        logic signed [127:0] obj;
        logic signed [127:0] inc;
        logic                take;
        out_item_t           d;
        int                  r;
        obj  = 128'(it.objective) <<< 16;
        take = obj >= 128'(dot_sum);
        col_counter++;
        if (take)
            for (int k = 0; k < buf_fill; k++)
            begin
                r   = buf_row[k];
                inc = $signed({1'b0, step_q}) *
                      (128'(buf_val[k]) - 128'(share_mem[r]));
                inc = inc / 65536;
                price_mem[r] = clamp_price(r, sat_price(price_mem[r] + inc));
                stamp_mem[r] = col_counter;
            end
        d.out_column_id   = it.column_id;
        d.take_column     = take;
        d.buffer_overflow = buf_over;
        decision_q.push_back(d);
        dot_sum  = 0;
        buf_fill = 0;
        buf_over = 0;
    endtask

    task automatic predict_item(input in_item_t it);
        logic signed [127:0] s;
        int r;
        r = it.row_index;
        case (func_t'(it.func))
            FUNC_LOAD:
            begin
                price_mem[r] = init_one_q ? 32'sh0001_0000 : 32'sh0;
                share_mem[r] = it.row_share;
                eq_mem[r]    = it.is_equality;
                stamp_mem[r] = col_counter;
            end
            FUNC_CLOSE:
                close_column(it);
            FUNC_ENTRY:
            begin
                decay_price(r);
                s = 128'(dot_sum) + 128'(it.entry_value) * 128'(price_mem[r]);
                if (s > 128'sh7FFF_FFFF_FFFF_FFFF)
                    dot_sum = 64'sh7FFF_FFFF_FFFF_FFFF;
                else if (s < -128'sh8000_0000_0000_0000)
                    dot_sum = 64'sh8000_0000_0000_0000;
                else
                    dot_sum = s[63:0];
                if (buf_fill < NBUF)
                begin
                    buf_row[buf_fill] = it.row_index;
                    buf_val[buf_fill] = it.entry_value;
                    buf_fill++;
                end
                else
                    buf_over = 1;
                if (it.last_in_column)
                    close_column(it);
            end
            default: ;
        endcase
    endtask

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        $display("decision %0d: %s got %0h want %0h", decisions_seen, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t w;
        if (!rst_n)
        begin
            step_q      = 0;
            init_one_q  = 0;
            col_counter = 0;
            dot_sum     = 0;
            buf_fill    = 0;
            buf_over    = 0;
            fail_count  = 0;
            decisions_seen = 0;
            takes_seen  = 0;
            decision_q.delete();
            pending_decisions = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == CFG_STEP_SIZE)
                    step_q = cfg_data;
                else
                    init_one_q = cfg_data[0];
            end
            if (out_valid && out_ready)
            begin
                if (decision_q.size() == 0)
                begin
                    $display("unexpected decision for column %0h", out_data.out_column_id);
                    fail_count++;
                end
                else
                begin
                    w = decision_q.pop_front();
                    if (out_data.out_column_id !== w.out_column_id)
                        report("column", out_data.out_column_id, w.out_column_id);
                    if (out_data.take_column !== w.take_column)
                        report("take", out_data.take_column, w.take_column);
                    if (out_data.buffer_overflow !== w.buffer_overflow)
                        report("overflow", out_data.buffer_overflow, w.buffer_overflow);
                    takes_seen += w.take_column;
                end
                decisions_seen++;
            end
            if (in_valid && in_ready)
                predict_item(in_data);
            pending_decisions = decision_q.size();
        end
    end

endmodule

@@ dv/online_lp_dual_update_engine_test.sv @@
// Stimulus and verdict for the online LP dual update engine
`timescale 1ns / 1ps
module online_lp_dual_update_engine_test;
    import olp_pkg::*;

    localparam int CYCLE_LIMIT = 900000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_ready;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_ready = 0;
    out_item_t   out_data;
    logic        cfg_write = 0;
    logic        cfg_index = CFG_STEP_SIZE;
    logic [15:0] cfg_data = 0;
    int          fail_count;
    int          pending_decisions;
    int          decisions_seen;
    int          takes_seen;
    int          cycles = 0;
    int          stall_mode = 0;
    int          items_sent = 0;
    logic        row_loaded [1024];
    int          loaded_rows[$];

    always #5 clk = ~clk;

    online_lp_dual_update_engine u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    online_lp_dual_update_checker u_check (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_decisions(pending_decisions),
        .decisions_seen(decisions_seen), .takes_seen(takes_seen)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("online_lp_dual_update_engine: mismatch");
            $finish;
        end
    end

    // Receiver stalls: mode 1 holds off for a long stretch, mode 2 never stalls
    always @(posedge clk)
    begin
        int hold;
        if (stall_mode == 1)
        begin
            out_ready <= 0;
            hold = 0;
            while (hold < 600)
            begin
                @(posedge clk);
                hold++;
            end
            out_ready <= 1;
            stall_mode = 0;
        end
        else if (stall_mode == 2)
            out_ready <= 1;
        else
            out_ready <= ($urandom_range(0, 3) != 0);
    end

    function automatic int wide_value();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $urandom();
            default: return int'($urandom_range(0, 262144)) - 131072;
        endcase
    endfunction

    task automatic idle_gap();
        int n;
        n = $urandom_range(0, 9) == 0 ? $urandom_range(5, 40) : $urandom_range(0, 2);
        repeat (n) @(posedge clk);
    endtask

    // Offer one transaction and hold it until accepted
    task automatic offer(input in_item_t it, input logic gaps);
        if (it.func == FUNC_LOAD && !row_loaded[it.row_index])
        begin
            row_loaded[it.row_index] = 1;
            loaded_rows.push_back(it.row_index);
        end
        in_data  <= it;
        in_valid <= 1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        if (gaps && $urandom_range(0, 2) == 0)
        begin
            in_valid <= 0;
            idle_gap();
        end
    endtask

    task automatic send_load(input int r, input logic [31:0] share, input logic eq,
                             input logic gaps);
        in_item_t it;
        it = '0;
        it.func = FUNC_LOAD;
        it.row_index = 10'(r);
        it.row_share = share;
        it.is_equality = eq;
        it.entry_value = $urandom();
        it.objective = $urandom();
        it.column_id = 16'($urandom());
        offer(it, gaps);
    endtask

    // A column of n entries over loaded rows; n of zero is an empty close
    task automatic send_column(input int n, input logic gaps);
        in_item_t it;
        for (int k = 0; k <= n; k++)
        begin
            if (k == n && n != 0)
                break;
            it = '0;
            it.func = (n == 0) ? FUNC_CLOSE : FUNC_ENTRY;
            it.row_index = 10'(loaded_rows[$urandom_range(0, loaded_rows.size() - 1)]);
            it.entry_value = wide_value();
            it.row_share = $urandom();
            it.is_equality = 1'($urandom());
            it.column_id = 16'($urandom());
            it.objective = wide_value();
            it.last_in_column = (k == n - 1);
            if (n == 0)
                it.last_in_column = 1'($urandom());
            offer(it, gaps);
        end
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (pending_decisions != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] v);
        cfg_write <= 1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 0;
    endtask

    initial
    begin
        in_item_t it;
        int       len;
        for (int r = 0; r < 1024; r++)
            row_loaded[r] = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: extreme rows, shares and values, every function
        write_reg(CFG_STEP_SIZE, 16'hFFFF);
        write_reg(CFG_DUAL_INIT_ONE, 1);
        send_load(0, 32'sh8000_0000, 0, 0);
        send_load(1023, 32'sh7FFF_FFFF, 1, 0);
        send_load(512, 32'sh0000_8000, 0, 0);
        send_load(5, 32'sh0, 1, 0);
        send_column(1, 0);
        send_column(3, 0);
        send_column(0, 0);
        it = '0;
        it.func = FUNC_NONE;
        it.row_index = 10'h3FF;
        it.entry_value = 32'hFFFF_FFFF;
        it.row_share = 32'hFFFF_FFFF;
        it.is_equality = 1;
        it.column_id = 16'hFFFF;
        it.objective = 32'hFFFF_FFFF;
        it.last_in_column = 1;
        offer(it, 0);
        send_column(66, 0);
        send_column(2, 0);
        drain();

        write_reg(CFG_STEP_SIZE, 0);
        write_reg(CFG_DUAL_INIT_ONE, 0);
        send_column(4, 1);
        send_column(0, 1);
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            write_reg(CFG_STEP_SIZE, phase == 3 ? 16'hFFFF : 16'($urandom_range(1, 4000)));
            write_reg(CFG_DUAL_INIT_ONE, phase[0]);
            if (phase == 1)
                stall_mode = 1;
            if (phase == 2)
                stall_mode = 2;
            repeat (8)
                send_load($urandom_range(0, 1023), wide_value(), 1'($urandom()), 1);
            while (items_sent < 250 + phase * 230)
            begin
                case ($urandom_range(0, 19))
                    0:
                        send_load(loaded_rows[$urandom_range(0, loaded_rows.size() - 1)],
                                  wide_value(), 1'($urandom()), 1);
                    1:
                        send_column(0, 1);
                    2:
                    begin
                        it = '0;
                        it.func = FUNC_NONE;
                        it.row_index = 10'($urandom());
                        it.column_id = 16'($urandom());
                        offer(it, 1);
                    end
                    3:
                        send_column($urandom_range(60, 70), 1);
                    default:
                    begin
                        len = $urandom_range(1, 6);
                        send_column(len, 1);
                    end
                endcase
            end
            drain();
            stall_mode = 0;
        end

        $display("sent %0d transactions, %0d decisions checked, %0d columns taken",
                 items_sent, decisions_seen, takes_seen);
        if (fail_count == 0)
            $display("online_lp_dual_update_engine: match");
        else
            $display("online_lp_dual_update_engine: mismatch");
        $finish;
    end

endmodule

@@ online_lp_dual_update_engine.f @@
+incdir+sv
sv/olp_pkg.sv
sv/olp_ram.sv
sv/online_lp_dual_update_engine.sv
dv/online_lp_dual_update_checker.sv
dv/online_lp_dual_update_engine_test.sv
